### rtl/core/rps_pkg.sv
// ----------------------------------------------------------------------------
// rps_pkg
// Shared codes and constants for the ready process scheduler.
// ----------------------------------------------------------------------------
package rps_pkg;

  localparam int DEFAULT_MAX_PROCS = 32;
  localparam int PRIO_W            = 10;
  localparam int PID_OUT_W         = 5;
  localparam int CFG_DATA_W        = 10;

  localparam logic [1:0] CMD_CREATE   = 2'd0;
  localparam logic [1:0] CMD_BLOCK    = 2'd1;
  localparam logic [1:0] CMD_FINISH   = 2'd2;
  localparam logic [1:0] CMD_SCHEDULE = 2'd3;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_RR    = 2'd1;
  localparam logic [1:0] POL_PRIO  = 2'd2;

  localparam logic REG_POLICY_MODE    = 1'b0;
  localparam logic REG_PRIORITY_FLOOR = 1'b1;

endpackage

### rtl/core/rps_ram.sv
// ----------------------------------------------------------------------------
// rps_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module rps_ram #(
  parameter int WIDTH = rps_pkg::PRIO_W,
  parameter int DEPTH = rps_pkg::DEFAULT_MAX_PROCS,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/ready_process_scheduler_core.sv
// ----------------------------------------------------------------------------
// ready_process_scheduler_core
// Process table with ready, blocked and finished marks and a priority per
// slot; creates, blocks, finishes and schedules processes.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Create, block and
// finish items give their result on the next cycle. A schedule item walks the
// process table one slot per cycle through the read port of the priority RAM,
// with one shared priority compare, and gives its result once the walk has
// ended and the resolve state has settled the pick. Each result is shown
// for exactly one cycle with done high; the receiver cannot stall it, so it
// must be taken in that cycle.
module ready_process_scheduler_core #(
  parameter int MAX_PROCS = rps_pkg::DEFAULT_MAX_PROCS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    cmd,
  input  logic [rps_pkg::PRIO_W-1:0]    new_priority,
  input  logic [4:0]                    rr_start,
  output logic                          done,
  output logic [rps_pkg::PID_OUT_W-1:0] chosen_pid,
  output logic                          none_found,
  output logic                          was_unblocked,
  output logic                          table_full,
  input  logic                          cfg_we,
  input  logic                          cfg_addr,
  input  logic [rps_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int PW = (CW > rps_pkg::PID_OUT_W) ? CW : rps_pkg::PID_OUT_W;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_SCAN    = 2'd1;
  localparam logic [1:0] ST_RESOLVE = 2'd2;

  logic [1:0]                 state;
  logic [1:0]                 policy_mode;
  logic [rps_pkg::PRIO_W-1:0] priority_floor;

  logic [MAX_PROCS-1:0] ready;
  logic [MAX_PROCS-1:0] blocked;
  logic [MAX_PROCS-1:0] finished;
  logic [CW-1:0]        count;
  logic [IW-1:0]        running_pid;

  logic [CW-1:0]              idx;
  logic                       s_valid;
  logic [IW-1:0]              s_idx;
  logic [PW-1:0]              pos;
  logic [rps_pkg::PRIO_W-1:0] top;
  logic                       found;
  logic [IW-1:0]              pick;
  logic                       bfound;
  logic [IW-1:0]              bidx;

  logic                       ram_we;
  logic [rps_pkg::PRIO_W-1:0] prio_rd;
  logic                       cnt_room;
  logic [PW-1:0]              start_ext;
  logic [PW-1:0]              cnt_ext;

  logic hit;
  logic take;
  logic bhit;

  logic [MAX_PROCS-1:0] ready_next;
  logic [MAX_PROCS-1:0] blocked_next;
  logic                 has_pick;
  logic [IW-1:0]        pick_next;
  logic                 unblk_next;

  assign busy      = (state != ST_IDLE);
  assign cnt_room  = (count < CW'(MAX_PROCS));
  assign ram_we    = start && !busy && (cmd == rps_pkg::CMD_CREATE) && cnt_room;
  assign start_ext = PW'(rr_start);
  assign cnt_ext   = PW'(count);

  rps_ram #(
    .WIDTH(rps_pkg::PRIO_W),
    .DEPTH(MAX_PROCS)
  ) u_prio_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count[IW-1:0]),
    .wdata(new_priority),
    .raddr(idx[IW-1:0]),
    .rdata(prio_rd)
  );

  // one slot per cycle: first ready, RR from pos, PRIO above running best
  always_comb begin
    hit  = s_valid && ready[s_idx];
    bhit = s_valid && blocked[s_idx] && !bfound;
    unique case (policy_mode)
      rps_pkg::POL_RR:   take = hit && !found && (PW'(s_idx) >= pos);
      rps_pkg::POL_PRIO: take = hit && (prio_rd > top);
      default:           take = hit && !found;
    endcase
  end

  always_comb begin
    ready_next   = ready;
    blocked_next = blocked;
    has_pick     = 1'b1;
    pick_next    = pick;
    unblk_next   = 1'b0;
    if (!found) begin
      if (bfound) begin
        blocked_next[bidx] = 1'b0;
        ready_next[bidx]   = 1'b1;
        pick_next          = bidx;
        unblk_next         = 1'b1;
      end else if (!finished[running_pid]) begin
        pick_next = running_pid;
      end else begin
        has_pick = 1'b0;
      end
    end
    if (has_pick) begin
      if (!blocked_next[running_pid] && !finished[running_pid]) begin
        ready_next[running_pid] = 1'b1;
      end
      ready_next[pick_next] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      policy_mode    <= rps_pkg::POL_FIRST;
      priority_floor <= '0;
      ready          <= '0;
      blocked        <= '0;
      finished       <= '0;
      count          <= '0;
      running_pid    <= '0;
      done           <= 1'b0;
      s_valid        <= 1'b0;
      found          <= 1'b0;
      bfound         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          rps_pkg::REG_POLICY_MODE:    policy_mode    <= cfg_data[1:0];
          rps_pkg::REG_PRIORITY_FLOOR: priority_floor <= cfg_data;
          default:                     ;
        endcase
      end
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            chosen_pid    <= '0;
            none_found    <= 1'b0;
            was_unblocked <= 1'b0;
            table_full    <= 1'b0;
            unique case (cmd)
              rps_pkg::CMD_CREATE: begin
                done <= 1'b1;
                if (cnt_room) begin
                  ready[count[IW-1:0]]    <= 1'b1;
                  blocked[count[IW-1:0]]  <= 1'b0;
                  finished[count[IW-1:0]] <= 1'b0;
                  count                   <= count + CW'(1);
                  chosen_pid              <= rps_pkg::PID_OUT_W'(count[IW-1:0]);
                end else begin
                  table_full <= 1'b1;
                end
              end
              rps_pkg::CMD_BLOCK: begin
                done                 <= 1'b1;
                blocked[running_pid] <= 1'b1;
                ready[running_pid]   <= 1'b0;
              end
              rps_pkg::CMD_FINISH: begin
                done                  <= 1'b1;
                finished[running_pid] <= 1'b1;
                ready[running_pid]    <= 1'b0;
              end
              default: begin
                idx     <= '0;
                s_valid <= 1'b0;
                found   <= 1'b0;
                bfound  <= 1'b0;
                top     <= priority_floor;
                if ((count != '0) && (start_ext == cnt_ext - PW'(1))) begin
                  pos <= '0;
                end else begin
                  pos <= start_ext;
                end
                state <= ST_SCAN;
              end
            endcase
          end
        end
        ST_SCAN: begin
          s_valid <= (idx < count);
          s_idx   <= idx[IW-1:0];
          if (idx < count) begin
            idx <= idx + CW'(1);
          end
          if (take) begin
            found <= 1'b1;
            pick  <= s_idx;
            top   <= prio_rd;
          end
          if (bhit) begin
            bfound <= 1'b1;
            bidx   <= s_idx;
          end
          if ((idx == count) && !s_valid) begin
            state <= ST_RESOLVE;
          end
        end
        ST_RESOLVE: begin
          ready         <= ready_next;
          blocked       <= blocked_next;
          done          <= 1'b1;
          none_found    <= !has_pick;
          was_unblocked <= unblk_next;
          chosen_pid    <= has_pick ? rps_pkg::PID_OUT_W'(pick_next) : '0;
          if (has_pick) begin
            running_pid <= pick_next;
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_PROCS))
    else $error("process count past table size");

  a_none_clean: assert property (@(posedge clk) disable iff (rst)
    done && none_found |-> (chosen_pid == '0) && !was_unblocked && !table_full)
    else $error("none found with other result fields set");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && table_full |-> count == CW'(MAX_PROCS))
    else $error("table full reported with free slots");

  a_sched_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (cmd == rps_pkg::CMD_SCHEDULE) |=> busy && !done)
    else $error("schedule item did not start a scan");

  a_run_not_ready: assert property (@(posedge clk) disable iff (rst)
    done && was_unblocked |-> !ready[running_pid] && !blocked[running_pid])
    else $error("unblocked pick left ready or blocked");

endmodule
